@@ rtl/ppq_pkg.sv @@
package ppq_pkg;

    // Fixed field widths of the item formats.
    localparam int unsigned USER_W  = 16;
    localparam int unsigned PRIO_W  = 4;
    localparam int unsigned FTIME_W = 32;
    localparam int unsigned ARR_W   = 16;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W       = 3;
    localparam int unsigned CFG_DATA_W       = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_PREEMPT_ENABLE = 3'd0;

    // Event kinds carried in s_tuser.
    typedef enum logic [1:0] {
        KIND_ARRIVAL = 2'd0,
        KIND_STATUS  = 2'd1,
        KIND_RETURN  = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    // Controller state, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted item and start the head read
        logic commit;  // apply the event and load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } dp_status_t;

endpackage

@@ rtl/ppq_ctrl.sv @@
module ppq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ppq_pkg::dp_status_t status,
    output ppq_pkg::dp_cmd_t    cmd
);
    import ppq_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == ST_EXEC) && status.out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Waits here while the previous result has not been taken.
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/ppq_datapath.sv @@
module ppq_datapath #(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ppq_pkg::dp_cmd_t             cmd,
    output ppq_pkg::dp_status_t          status,
    input  logic                         preempt_enable,
    input  ppq_pkg::kind_t               in_kind,
    input  logic [ppq_pkg::USER_W-1:0]   in_user_id,
    input  logic [ppq_pkg::PRIO_W-1:0]   in_priority,
    input  logic [ppq_pkg::FTIME_W-1:0]  in_wait,
    input  logic [ppq_pkg::FTIME_W-1:0]  in_now,
    input  logic                         in_busy,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic                         out_dispatch,
    output logic [ppq_pkg::USER_W-1:0]   out_user,
    output logic [ppq_pkg::PRIO_W-1:0]   out_priority,
    output logic [ppq_pkg::FTIME_W-1:0]  out_wait,
    output logic [ppq_pkg::ARR_W-1:0]    out_arrivals,
    output logic                         out_dropped,
    output logic [$clog2(DEPTH+1)-1:0]   out_level
);
    import ppq_pkg::*;

    localparam int unsigned AW      = $clog2(DEPTH);
    localparam int unsigned CW      = $clog2(DEPTH + 1);
    localparam int unsigned SW      = CW + 1;
    localparam int unsigned TW      = (TIME_BITS < FTIME_W) ? TIME_BITS : FTIME_W;
    localparam int unsigned ENTRY_W = USER_W + PRIO_W + 2 * TW;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [TW-1:0] TMAX     = '1;
    localparam logic [ARR_W-1:0] ARR_MAX = '1;

    // Held event.
    kind_t             kind_reg;
    logic [USER_W-1:0] user_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [TW-1:0]     wait_reg;
    logic [TW-1:0]     now_reg;
    logic              busy_req_reg;

    // Control state.
    logic              server_busy_reg;
    logic [PRIO_W-1:0] server_prio_reg;
    logic [ARR_W-1:0]  arrivals_reg;
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;

    // Deque storage and its registered head read.
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_q;

    logic [USER_W-1:0] rd_user;
    logic [PRIO_W-1:0] rd_prio;
    logic [TW-1:0]     rd_wait;
    logic [TW-1:0]     rd_join;

    logic pop;
    logic push_tail;
    logic push_head;
    logic direct;
    logic drop;
    logic rd_arr;
    logic full;

    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_next;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail_idx;

    logic [TW-1:0] delta;
    logic [TW:0]   wait_sum;
    logic [TW-1:0] pop_wait;

    logic              we;
    logic [AW-1:0]     wa;

    assign {rd_join, rd_wait, rd_prio, rd_user} = rd_q;

    assign full = (count_reg == FULL_CNT);

    always_comb begin
        pop       = 1'b0;
        push_tail = 1'b0;
        push_head = 1'b0;
        direct    = 1'b0;
        drop      = 1'b0;
        rd_arr    = 1'b0;
        case (kind_reg)
            KIND_ARRIVAL: begin
                if (!server_busy_reg) begin
                    direct = 1'b1;
                end else if (!preempt_enable || (server_prio_reg <= prio_reg)) begin
                    drop      = full;
                    push_tail = !full;
                end else if (count_reg == '0) begin
                    direct = 1'b1;
                end else begin
                    // The head leaves first, so a full deque still takes the arrival.
                    pop       = 1'b1;
                    push_tail = 1'b1;
                end
            end
            KIND_STATUS: begin
                pop = !busy_req_reg && (count_reg != '0);
            end
            KIND_RETURN: begin
                drop      = full;
                push_head = !full;
            end
            KIND_READ: begin
                rd_arr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Ring pointer arithmetic; DEPTH need not be a power of two.
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

    always_comb begin
        head_next = head_reg;
        if (push_head) begin
            head_next = head_dec;
        end else if (pop) begin
            head_next = head_inc;
        end
        count_next = count_reg;
        if ((push_tail || push_head) && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push_tail) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Wait update: modular time difference, saturating sum.
    assign delta    = now_reg - rd_join;
    assign wait_sum = {1'b0, rd_wait} + {1'b0, delta};
    assign pop_wait = wait_sum[TW] ? TMAX : wait_sum[TW-1:0];

    assign we = cmd.commit && (push_tail || push_head);
    assign wa = push_head ? head_dec : tail_idx;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= {now_reg, wait_reg, prio_reg, user_reg};
        end
        rd_q <= mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg     <= in_kind;
            user_reg     <= in_user_id;
            prio_reg     <= in_priority;
            wait_reg     <= in_wait[TW-1:0];
            now_reg      <= in_now[TW-1:0];
            busy_req_reg <= in_busy;
        end
    end

    assign status.out_free = !m_tvalid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_busy_reg <= 1'b0;
            server_prio_reg <= '0;
            arrivals_reg    <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            m_tvalid        <= 1'b0;
        end else begin
            if (cmd.commit) begin
                head_reg  <= head_next;
                count_reg <= count_next;
                m_tvalid  <= 1'b1;
                if (kind_reg == KIND_ARRIVAL) begin
                    if (arrivals_reg != ARR_MAX) begin
                        arrivals_reg <= arrivals_reg + ARR_W'(1);
                    end
                    if (!server_busy_reg) begin
                        server_busy_reg <= 1'b1;
                    end
                end
                if (kind_reg == KIND_STATUS) begin
                    server_busy_reg <= busy_req_reg;
                    server_prio_reg <= prio_reg;
                end
                if (rd_arr) begin
                    arrivals_reg <= '0;
                end
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // Result register; fields that mean nothing in a step are zero.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_dispatch <= direct || pop;
            out_user     <= direct ? user_reg : (pop ? rd_user : '0);
            out_priority <= direct ? prio_reg : (pop ? rd_prio : '0);
            out_wait     <= direct ? FTIME_W'(wait_reg) : (pop ? FTIME_W'(pop_wait) : '0);
            out_arrivals <= rd_arr ? arrivals_reg : '0;
            out_dropped  <= drop;
            out_level    <= count_next;
        end
    end

endmodule

@@ rtl/preemptive_priority_queue_ctrl.sv @@
// Channel   Ports                      Contents
// input     s_tvalid/s_tready          s_tuser = kind; s_tdata = user, priority, wait,
//                                      time stamp, busy flag
// result    m_tvalid/m_tready          m_tuser = dispatch flag; m_tdata = user,
//                                      priority, wait, arrival count, dropped, level
// config    psel/penable/pwrite/paddr  register 0 at byte address 0: preempt_enable
//
// Every item is first captured while the deque head is read from the
// synchronous memory; then the event is applied and the result register is loaded.
// The input is ready again only once that result is loaded, so items are taken one at a time.
// Reset is synchronous and active low; it clears the pointers, the count and the
// server state, and the deque memory needs no clearing because it is only read
// inside the occupied region. A stalled result holds the block in its apply step.
module preemptive_priority_queue_ctrl #(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] user_id, [19:16] priority_req, [51:20] wait_so_far, [83:52] now,
    // [84] busy_req, zero filled above.
    input  logic [87:0]                        s_tdata,
    // [1:0] kind.
    input  logic [1:0]                         s_tuser,
    // Result items.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] out_user, [19:16] out_priority, [51:20] out_wait, [67:52] arrival_count,
    // [68] dropped, level above, zero filled to whole bytes.
    output logic [((69 + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata,
    // [0] dispatch_valid.
    output logic                               m_tuser,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppq_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ppq_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ppq_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import ppq_pkg::*;

    localparam int unsigned LVL_W  = $clog2(DEPTH + 1);
    localparam int unsigned USED_W = USER_W + PRIO_W + FTIME_W + ARR_W + 1 + LVL_W;
    localparam int unsigned MD_W   = ((USED_W + 7) / 8) * 8;

    logic preempt_enable_reg;

    dp_cmd_t    cmd;
    dp_status_t status;

    logic                out_dispatch;
    logic [USER_W-1:0]   out_user;
    logic [PRIO_W-1:0]   out_priority;
    logic [FTIME_W-1:0]  out_wait;
    logic [ARR_W-1:0]    out_arrivals;
    logic                out_dropped;
    logic [LVL_W-1:0]    out_level;

    // The single configuration register. Writes land on the access cycle; reads
    // return the register, and any other address reads as zero.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preempt_enable_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == REG_PREEMPT_ENABLE)) begin
            preempt_enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == REG_PREEMPT_ENABLE) ?
                    CFG_DATA_W'(preempt_enable_reg) : '0;

    // The controller sequences capture and apply; the datapath holds the deque,
    // the server state and the result register.
    ppq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppq_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .preempt_enable (preempt_enable_reg),
        .in_kind        (kind_t'(s_tuser)),
        .in_user_id     (s_tdata[15:0]),
        .in_priority    (s_tdata[19:16]),
        .in_wait        (s_tdata[51:20]),
        .in_now         (s_tdata[83:52]),
        .in_busy        (s_tdata[84]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_dispatch   (out_dispatch),
        .out_user       (out_user),
        .out_priority   (out_priority),
        .out_wait       (out_wait),
        .out_arrivals   (out_arrivals),
        .out_dropped    (out_dropped),
        .out_level      (out_level)
    );

    // Result packing, lowest field first.
    assign m_tuser = out_dispatch;
    assign m_tdata = MD_W'({out_level, out_dropped, out_arrivals, out_wait,
                            out_priority, out_user});

endmodule

@@ dv/ppq_checker.sv @@
module ppq_checker #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [87:0]                      s_tdata,
    input  logic [1:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [((69 + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                             m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppq_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ppq_pkg::CFG_DATA_W-1:0]   pwdata,
    input  logic [ppq_pkg::CFG_DATA_W-1:0]   prdata,
    input  logic                             pready,
    output int                               fail_count,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppq_pkg::*;

    localparam int unsigned LVL_W = $clog2(DEPTH + 1);
    localparam int unsigned M_W   = ((69 + LVL_W + 7) / 8) * 8;
    localparam int unsigned AW    = $clog2(DEPTH);

    typedef struct packed {
        logic               disp;
        logic [USER_W-1:0]  user;
        logic [PRIO_W-1:0]  prio;
        logic [FTIME_W-1:0] waited;
        logic [ARR_W-1:0]   acount;
        logic               dropped;
        logic [LVL_W-1:0]   level;
    } dispatch_t;

    // Shadow of the block: configuration, server state and the waiting line.
    logic               preempt_on;
    logic               srv_busy;
    logic [PRIO_W-1:0]  srv_prio;
    logic [ARR_W-1:0]   arr_cnt;
    logic [USER_W-1:0]  line_user   [DEPTH];
    logic [PRIO_W-1:0]  line_prio   [DEPTH];
    logic [FTIME_W-1:0] line_waited [DEPTH];
    logic [FTIME_W-1:0] line_joined [DEPTH];
    int unsigned        head_ptr;
    int unsigned        n_waiting;

    dispatch_t due_dispatches [$];
    int        mismatches = 0;

    function automatic logic [FTIME_W-1:0] grown_wait(input logic [FTIME_W-1:0] w,
                                                       input logic [FTIME_W-1:0] t,
                                                       input logic [FTIME_W-1:0] joined);
        logic [FTIME_W-1:0] d;
        d = t - joined;
        if (d > ({FTIME_W{1'b1}} - w))
            return {FTIME_W{1'b1}};
        return w + d;
    endfunction

    function automatic dispatch_t serve_head(input logic [FTIME_W-1:0] t);
        dispatch_t r;
        r        = '0;
        r.disp   = 1'b1;
        r.user   = line_user[AW'(head_ptr)];
        r.prio   = line_prio[AW'(head_ptr)];
        r.waited = grown_wait(line_waited[AW'(head_ptr)], t, line_joined[AW'(head_ptr)]);
        head_ptr  = (head_ptr + 1) % DEPTH;
        n_waiting = n_waiting - 1;
        return r;
    endfunction

    function automatic void queue_tail(input logic [USER_W-1:0] u, input logic [PRIO_W-1:0] p,
                                       input logic [FTIME_W-1:0] w,
                                       input logic [FTIME_W-1:0] t);
        int unsigned slot;
        slot = (head_ptr + n_waiting) % DEPTH;
        line_user[AW'(slot)]   = u;
        line_prio[AW'(slot)]   = p;
        line_waited[AW'(slot)] = w;
        line_joined[AW'(slot)] = t;
        n_waiting = n_waiting + 1;
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        dispatch_t          got;
        dispatch_t          want;
        kind_t              ev_kind;
        logic [USER_W-1:0]  ev_user;
        logic [PRIO_W-1:0]  ev_prio;
        logic [FTIME_W-1:0] ev_wait;
        logic [FTIME_W-1:0] ev_now;
        logic               ev_busy;
        logic               line_full;

        if (!aresetn) begin
            preempt_on = 1'b0;
            srv_busy   = 1'b0;
            srv_prio   = '0;
            arr_cnt    = '0;
            head_ptr   = 0;
            n_waiting  = 0;
            due_dispatches.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == REG_PREEMPT_ENABLE)
                        preempt_on = pwdata[0];
                end else if (prdata !== {{(CFG_DATA_W-1){1'b0}}, preempt_on}) begin
                    report("prdata", {{(CFG_DATA_W-1){1'b0}}, preempt_on}, prdata);
                end
            end

            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[15:0], m_tdata[19:16], m_tdata[51:20],
                       m_tdata[67:52], m_tdata[68], m_tdata[68+LVL_W:69]};
                if (due_dispatches.size() == 0) begin
                    $display("%0t ns: result item with none expected, expected none, actual %0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = due_dispatches.pop_front();
                    if (got.disp !== want.disp)
                        report("dispatch_valid", 32'(want.disp), 32'(got.disp));
                    if (got.user !== want.user)
                        report("out_user", 32'(want.user), 32'(got.user));
                    if (got.prio !== want.prio)
                        report("out_priority", 32'(want.prio), 32'(got.prio));
                    if (got.waited !== want.waited)
                        report("out_wait", want.waited, got.waited);
                    if (got.acount !== want.acount)
                        report("arrival_count", 32'(want.acount), 32'(got.acount));
                    if (got.dropped !== want.dropped)
                        report("dropped", 32'(want.dropped), 32'(got.dropped));
                    if (got.level !== want.level)
                        report("level", 32'(want.level), 32'(got.level));
                end
                if (m_tdata[M_W-1:69+LVL_W] !== '0)
                    report("m_tdata padding", 32'h0, 32'(m_tdata[M_W-1:69+LVL_W]));
            end

            if (s_tvalid && s_tready) begin
                ev_kind   = kind_t'(s_tuser);
                ev_user   = s_tdata[15:0];
                ev_prio   = s_tdata[19:16];
                ev_wait   = s_tdata[51:20];
                ev_now    = s_tdata[83:52];
                ev_busy   = s_tdata[84];
                line_full = (n_waiting >= DEPTH);
                want      = '0;
                case (ev_kind)
                    KIND_ARRIVAL: begin
                        if (arr_cnt != {ARR_W{1'b1}})
                            arr_cnt = arr_cnt + ARR_W'(1);
                        if (!srv_busy) begin
                            want.disp   = 1'b1;
                            want.user   = ev_user;
                            want.prio   = ev_prio;
                            want.waited = ev_wait;
                            srv_busy    = 1'b1;
                        end else if (!preempt_on || srv_prio <= ev_prio) begin
                            if (line_full)
                                want.dropped = 1'b1;
                            else
                                queue_tail(ev_user, ev_prio, ev_wait, ev_now);
                        end else if (n_waiting == 0) begin
                            want.disp   = 1'b1;
                            want.user   = ev_user;
                            want.prio   = ev_prio;
                            want.waited = ev_wait;
                        end else begin
                            // The head leaves first, so a full line still takes the arrival.
                            want = serve_head(ev_now);
                            queue_tail(ev_user, ev_prio, ev_wait, ev_now);
                        end
                    end
                    KIND_STATUS: begin
                        srv_busy = ev_busy;
                        srv_prio = ev_prio;
                        if (!srv_busy && n_waiting != 0)
                            want = serve_head(ev_now);
                    end
                    KIND_RETURN: begin
                        if (line_full) begin
                            want.dropped = 1'b1;
                        end else begin
                            head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
                            line_user[AW'(head_ptr)]   = ev_user;
                            line_prio[AW'(head_ptr)]   = ev_prio;
                            line_waited[AW'(head_ptr)] = ev_wait;
                            line_joined[AW'(head_ptr)] = ev_now;
                            n_waiting = n_waiting + 1;
                        end
                    end
                    KIND_READ: begin
                        want.acount = arr_cnt;
                        arr_cnt     = '0;
                    end
                    default: begin
                    end
                endcase
                want.level = n_waiting[LVL_W-1:0];
                due_dispatches.push_back(want);
            end
        end
        pending    <= due_dispatches.size();
        fail_count <= mismatches;
    end

endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppq_pkg::*;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned M_W   = ((69 + $clog2(DEPTH + 1) + 7) / 8) * 8;

    // Traffic mixes for the random phases: a steady mixture, one that piles users
    // into the line behind a busy server, and one that keeps the server asking for more.
    typedef enum int {
        MIX_STEADY,
        MIX_FILL,
        MIX_DRAIN
    } mix_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [87:0]             s_tdata  = '0;
    logic [1:0]              s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_W-1:0]          m_tdata;
    logic                    m_tuser;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr    = '0;
    logic [CFG_DATA_W-1:0]   pwdata   = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    int          fail_count;
    int          pending;

    // Longest idle gap of the sender and longest stall of the receiver, per phase.
    int          tx_max = 3;
    int          rx_max = 17;
    logic [31:0] stamp  = '0;

    preemptive_priority_queue_ctrl #(
        .DEPTH(DEPTH),
        .TIME_BITS(32)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ppq_checker #(
        .DEPTH(DEPTH)
    ) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver holds m_tready low for a freshly drawn number of cycles after
    // every item it takes. The handshake is noted at the rising edge and acted
    // upon at the following falling edge, so m_tready gets one assignment per step.
    logic res_taken = 1'b0;
    int   rx_stall  = 0;

    always @(posedge aclk) begin
        res_taken <= m_tvalid && m_tready;
    end

    always @(negedge aclk) begin
        if (res_taken)
            rx_stall = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offers one item after a random gap and returns at the falling edge that
    // follows its acceptance. s_tvalid stays high when the next gap is zero.
    task automatic send_event(input kind_t k, input logic [15:0] u, input logic [3:0] p,
                              input logic [31:0] w, input logic [31:0] t, input logic b);
        int gap;
        gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {3'b000, b, t, w, p, u};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops sending and waits until every result item that is owed has been taken,
    // then lets the block settle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input logic wr, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_PREEMPT_ENABLE;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes the preemption switch and reads it back; the checker compares the read.
    task automatic set_preempt(input logic on);
        apb_transfer(1'b1, {{(CFG_DATA_W-1){1'b0}}, on});
        apb_transfer(1'b0, '0);
    endtask

    task automatic send_random(input mix_t mix);
        kind_t       k;
        logic        b;
        logic [31:0] w;
        int          r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                k = (r < 60) ? KIND_ARRIVAL : (r < 90) ? KIND_RETURN :
                    (r < 95) ? KIND_STATUS : KIND_READ;
                b = ($urandom_range(0, 9) != 0);
            end
            MIX_DRAIN: begin
                k = (r < 70) ? KIND_STATUS : (r < 85) ? KIND_ARRIVAL :
                    (r < 90) ? KIND_RETURN : KIND_READ;
                b = ($urandom_range(0, 4) == 0);
            end
            default: begin
                k = (r < 40) ? KIND_ARRIVAL : (r < 70) ? KIND_STATUS :
                    (r < 85) ? KIND_RETURN : KIND_READ;
                b = 1'($urandom_range(0, 1));
            end
        endcase
        // Waits are mostly small, but some sit right under the top so that
        // the sum saturates.
        case ($urandom_range(0, 3))
            0:       w = $urandom_range(0, 1000);
            1:       w = $urandom;
            2:       w = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: w = '0;
        endcase
        // The time stamp mostly creeps forward and now and then jumps anywhere,
        // which also makes it wrap around.
        if ($urandom_range(0, 19) == 0)
            stamp = $urandom;
        else
            stamp = stamp + $urandom_range(0, 50);
        send_event(k, 16'($urandom), 4'($urandom_range(0, 15)), w, stamp, b);
    endtask

    initial begin
        mix_t mix;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed part, preemption off first.
        set_preempt(1'b0);
        send_event(KIND_READ,    16'h0000, 4'h0, 32'h0000_0000, 32'h0000_0000, 1'b0);
        // Idle server: the arrival goes straight through.
        send_event(KIND_ARRIVAL, 16'h0000, 4'h0, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_event(KIND_ARRIVAL, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_event(KIND_ARRIVAL, 16'h1234, 4'h5, 32'h0000_0000, 32'h0000_0010, 1'b0);
        // A returned user goes in front of the head.
        send_event(KIND_RETURN,  16'hAAAA, 4'h3, 32'h0000_0007, 32'hFFFF_FFFF, 1'b1);
        send_event(KIND_STATUS,  16'h5555, 4'hF, 32'h0000_0000, 32'h0000_0020, 1'b1);
        // The time difference wraps round here.
        send_event(KIND_STATUS,  16'h0000, 4'h0, 32'h0000_0000, 32'h0000_0005, 1'b0);
        // Here the wait saturates.
        send_event(KIND_STATUS,  16'h0000, 4'h0, 32'h0000_0000, 32'h0000_0001, 1'b0);
        send_event(KIND_READ,    16'hFFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_event(KIND_READ,    16'h0000, 4'h0, 32'h0000_0000, 32'h0000_0000, 1'b0);
        settle();

        // Directed part with preemption on.
        set_preempt(1'b1);
        send_event(KIND_STATUS,  16'h0000, 4'h8, 32'h0000_0000, 32'h0000_0100, 1'b1);
        // Equal priority does not preempt.
        send_event(KIND_ARRIVAL, 16'h0101, 4'h8, 32'h0000_0001, 32'h0000_0110, 1'b0);
        send_event(KIND_ARRIVAL, 16'h0202, 4'h9, 32'h0000_0002, 32'h0000_0120, 1'b0);
        // Higher priority with a non-empty line: queued, and the head is served.
        send_event(KIND_ARRIVAL, 16'h0303, 4'h0, 32'h0000_1000, 32'h0000_0150, 1'b1);
        send_event(KIND_STATUS,  16'h0000, 4'h0, 32'h0000_0000, 32'h0000_0200, 1'b0);
        send_event(KIND_STATUS,  16'h0000, 4'h0, 32'h0000_0000, 32'h0000_0210, 1'b0);
        send_event(KIND_STATUS,  16'h0000, 4'h0, 32'h0000_0000, 32'h0000_0220, 1'b0);
        send_event(KIND_STATUS,  16'h0000, 4'hF, 32'h0000_0000, 32'h0000_0300, 1'b1);
        // Higher priority with an empty line: straight to the server.
        send_event(KIND_ARRIVAL, 16'hBEEF, 4'hE, 32'hFFFF_FFFF, 32'h0000_0301, 1'b0);
        send_event(KIND_RETURN,  16'hCAFE, 4'hF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_event(KIND_STATUS,  16'h0000, 4'hF, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_event(KIND_READ,    16'h0000, 4'h0, 32'h0000_0000, 32'h0000_0000, 1'b0);
        settle();

        // Random phases. Each one runs with its own mix, its own switch setting
        // and its own idling; the fill phases push the line to full, so inserts
        // are dropped and, with preemption on, a push and pop happens while full.
        for (int ph = 0; ph < 12; ph++) begin
            mix    = mix_t'(ph % 3);
            tx_max = (ph % 4 == 1) ? 0 : 17;
            rx_max = (ph % 5 == 2 || ph == 5) ? 0 : 17;
            set_preempt(((ph / 3) % 2) == 1);
            for (int n = 0; n < 140; n++) begin
                // Once in the run the sender holds off until the line of owed
                // results has emptied.
                if (ph == 4 && n == 70)
                    settle();
                send_random(mix);
            end
            settle();
        end

        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ppq_pkg.sv
rtl/ppq_ctrl.sv
rtl/ppq_datapath.sv
rtl/preemptive_priority_queue_ctrl.sv
dv/ppq_checker.sv
dv/tb.sv
